/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared widths, constants and round functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlkBytes = 64;
  localparam int unsigned BufAw = 4;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [63:0] digest_top;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_bottom;
  } digest_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } req_t;

  localparam logic ActAbsorb = 1'b0;
  localparam logic ActFinish = 1'b1;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sig0(word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t sig1(word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

/* sv/sha_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface sha_in_if import sha_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if import sha_pkg::*;;
  logic    valid;
  logic    ready;
  digest_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/sha_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* sv/sha_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round
// One compression round on the working variables.
// ----------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
  input  word_t       st_i [8],
  input  word_t       w_i,
  input  logic [5:0]  t_i,
  output word_t       st_o [8]
);
  word_t s1, ch, t1, s0, mj;

  always_comb begin
    s1 = rotr(st_i[4], 6) ^ rotr(st_i[4], 11) ^ rotr(st_i[4], 25);
    ch = (st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6]);
    t1 = st_i[7] + s1 + ch + RoundK[t_i] + w_i;
    s0 = rotr(st_i[0], 2) ^ rotr(st_i[0], 13) ^ rotr(st_i[0], 22);
    mj = (st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]);
    st_o[7] = st_i[6];
    st_o[6] = st_i[5];
    st_o[5] = st_i[4];
    st_o[4] = st_i[3] + t1;
    st_o[3] = st_i[2];
    st_o[2] = st_i[1];
    st_o[1] = st_i[0];
    st_o[0] = t1 + s0 + mj;
  end
endmodule

/* sv/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs one byte a request; a finish request pads and emits the digest.
// ----------------------------------------------------------------------------
// Absorb requests are taken while idle; the 64th byte of a block starts a
// compression: a load step, 16 rounds that read the block buffer, 48 rounds
// that first make four schedule-memory reads on one shared port, an add step.
// Finish pads the block byte by byte and runs one or two compressions, then
// loads the digest register once the output is free; new requests are taken
// while the digest waits. Reset restores the initial hash, counts, state, flags.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPad   = 7'b0000010,
    StLoad  = 7'b0000100,
    StRd    = 7'b0001000,
    StRound = 7'b0010000,
    StAdd   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  word_t chain_q [8];
  word_t work_q [8];
  word_t rnd_next [8];
  logic [5:0] fill_q;
  logic [63:0] msg_q;
  logic [5:0] t_q;
  logic [1:0] ph_q;
  logic fin_q, last_q, pad_q;
  word_t acc_q;
  digest_t dig_q;
  logic out_v_q;

  // Block buffer held as 16 words with byte write-merge through a partial-word register.
  logic [3:0] w_waddr, w_raddr;
  logic w_we;
  word_t w_wdata, w_rdata;
  logic [3:0] r_waddr, r_raddr;
  logic r_we;
  word_t r_wdata, r_rdata;
  word_t part_q;

  sha_ram #(.Width(32), .Depth(16)) u_blk (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata));
  sha_ram #(.Width(32), .Depth(16)) u_sched (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata));

  word_t wt;
  sha_round u_round (.st_i(work_q), .w_i(wt), .t_i(t_q), .st_o(rnd_next));

  wire acc = in_if.valid && in_if.ready;
  wire out_free = !out_v_q || out_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = out_v_q;
  assign out_if.payload = dig_q;

  logic [63:0] bitlen;
  assign bitlen = {msg_q[60:0], 3'b000};

  // Current byte to place, from absorb or padding.
  logic [7:0] pbyte;
  always_comb begin
    pbyte = 8'h00;
    if (state_q == StIdle) begin
      pbyte = in_if.payload.data_byte;
    end else if (fin_q) begin
      pbyte = 8'h80;
    end else if (last_q && fill_q >= 6'd56) begin
      pbyte = bitlen[8'(7 - (fill_q - 6'd56)) * 8 +: 8];
    end
  end

  wire place = (state_q == StIdle) ? (acc && in_if.payload.action == ActAbsorb)
                                   : (state_q == StPad);
  word_t merged;
  always_comb begin
    merged = part_q;
    merged[8'(3 - fill_q[1:0]) * 8 +: 8] = pbyte;
  end

  always_comb begin
    w_we = 1'b0;
    w_waddr = fill_q[5:2];
    w_wdata = merged;
    w_raddr = t_q[3:0];
    if (place) begin
      w_we = 1'b1;
    end
    r_we = 1'b0;
    r_waddr = t_q[3:0];
    r_raddr = t_q[3:0];
    wt = w_rdata;
    if (state_q == StRound && t_q >= 6'd16) begin
      wt = acc_q + r_rdata;
    end
    r_wdata = wt;
    if (state_q == StRound) begin
      r_we = 1'b1;
    end
    if (state_q == StRd) begin
      case (ph_q)
        2'd0: r_raddr = t_q[3:0] - 4'd15;
        2'd1: r_raddr = t_q[3:0] - 4'd2;
        2'd2: r_raddr = t_q[3:0] - 4'd7;
        default: r_raddr = t_q[3:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      part_q <= (fill_q[1:0] == 2'd3) ? '0 : merged;
    end
    if (state_q == StRd) begin
      case (ph_q)
        2'd1: acc_q <= sig0(r_rdata);
        2'd2: acc_q <= acc_q + sig1(r_rdata);
        2'd3: acc_q <= acc_q + r_rdata;
        default: acc_q <= acc_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc) begin
        if (in_if.payload.action == ActFinish) state_d = StPad;
        else if (fill_q == 6'd63) state_d = StLoad;
      end
      StPad: if (fill_q == 6'd63) state_d = StLoad;
      StLoad: state_d = StRd;
      StRd: if (t_q < 6'd16 || ph_q == 2'd3) state_d = StRound;
      StRound: state_d = (t_q == 6'd63) ? StAdd : StRd;
      StAdd: state_d = !pad_q ? StIdle : (last_q ? StOut : StPad);
      StOut: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chain_q <= Iv;
      work_q <= '{default: '0};
      fill_q <= '0;
      msg_q <= '0;
      t_q <= '0;
      ph_q <= '0;
      fin_q <= 1'b0;
      last_q <= 1'b0;
      pad_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_if.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        StIdle: if (acc) begin
          if (in_if.payload.action == ActFinish) begin
            fin_q <= 1'b1;
            pad_q <= 1'b1;
            last_q <= (fill_q < 6'd56);
          end else begin
            msg_q <= msg_q + 64'd1;
            fill_q <= fill_q + 6'd1;
          end
        end
        StPad: begin
          fin_q <= 1'b0;
          fill_q <= fill_q + 6'd1;
        end
        StLoad: begin
          work_q <= chain_q;
          t_q <= '0;
          ph_q <= '0;
        end
        StRd: ph_q <= (t_q < 6'd16) ? 2'd0 : ph_q + 2'd1;
        StRound: begin
          work_q <= rnd_next;
          t_q <= t_q + 6'd1;
          ph_q <= '0;
        end
        StAdd: begin
          for (int j = 0; j < 8; j++) chain_q[j] <= chain_q[j] + work_q[j];
          if (pad_q && !last_q) begin
            last_q <= 1'b1;
          end
        end
        StOut: if (out_free) begin
          dig_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                    chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
          chain_q <= Iv;
          msg_q <= '0;
          fill_q <= '0;
          last_q <= 1'b0;
          fin_q <= 1'b0;
          pad_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/sha_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the channel handshakes of the stream hasher.
// ----------------------------------------------------------------------------
module sha_checker import sha_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input digest_t out_payload_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("digest dropped while stalled");
  a_in_open_at_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("input closed when digest appeared");
  a_busy_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("digest without busy phase");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_i, out_valid_i}))
    else $error("handshake signal unknown");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_payload_i(out_if.payload));
